### rtl/core/dvc_pkg.sv
// Package for the distinct value counter: field widths, opcodes, FSM states
// and the beat structs shared by the cell chain and the controller.
// No dependencies.
`timescale 1ns / 1ps

package dvc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned COUNT_W_DEF = 32;

  // Fixed payload widths
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned TOTAL_W     = 7;

  // Opcodes; the fourth code does nothing
  typedef logic [1:0] op_t;
  localparam op_t OP_COUNT = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

  // Beat walking down the cell chain (count travels beside it)
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [VALUE_W-1:0] sample;
    logic [IDX_W-1:0]   idx;
    logic               hit;
    logic               fresh;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   pos;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic [VALUE_W-1:0]     entry_value;
    logic [OUT_COUNT_W-1:0] entry_count;
    logic [IDX_W-1:0]       entry_position;
    logic                   was_new;
    logic                   entry_valid;
    logic [TOTAL_W-1:0]     distinct_total;
    logic                   table_full;
  } res_t;

endpackage

### rtl/core/dvc_ifs.sv
// Valid/ready channel interfaces for the distinct value counter.
// Depends on dvc_pkg for the payload widths.
`timescale 1ns / 1ps

interface dvc_in_if;
  import dvc_pkg::*;
  logic               valid;
  logic               ready;
  op_t                opcode;
  logic [VALUE_W-1:0] sample_value;
  logic [IDX_W-1:0]   entry_index;

  modport source (output valid, opcode, sample_value, entry_index, input ready);
  modport sink   (input valid, opcode, sample_value, entry_index, output ready);
endinterface

interface dvc_out_if;
  import dvc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VALUE_W-1:0]     entry_value;
  logic [OUT_COUNT_W-1:0] entry_count;
  logic [IDX_W-1:0]       entry_position;
  logic                   was_new;
  logic                   entry_valid;
  logic [TOTAL_W-1:0]     distinct_total;
  logic                   table_full;

  modport source (output valid, entry_value, entry_count, entry_position, was_new,
                  entry_valid, distinct_total, table_full, input ready);
  modport sink   (input valid, entry_value, entry_count, entry_position, was_new,
                  entry_valid, distinct_total, table_full, output ready);
endinterface

### rtl/core/dvc_cell.sv
// One table cell: holds a value and its count, and passes the walking beat on.
// Depends on dvc_pkg.
`timescale 1ns / 1ps

module dvc_cell
  import dvc_pkg::*;
#(
  parameter int unsigned INDEX   = 0,
  parameter int unsigned COUNT_W = COUNT_W_DEF,
  parameter int unsigned USED_W  = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [USED_W-1:0]  used,
  input  beat_t              beat_i,
  input  logic [COUNT_W-1:0] cnt_i,
  output beat_t              beat_o,
  output logic [COUNT_W-1:0] cnt_o
);

  localparam int unsigned CMP_W = (USED_W > IDX_W) ? USED_W : IDX_W;
  localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX);

  logic [VALUE_W-1:0] val_r;
  logic [COUNT_W-1:0] cnt_r;
  beat_t              beat_r, beat_nxt;
  logic [COUNT_W-1:0] hcnt_r, hcnt_nxt;

  logic               occupied;
  logic               match_upd, append, read_hit;
  logic [COUNT_W-1:0] cnt_inc;

  // Entry is live when its position is below the fill count
  assign occupied = MY_POS < CMP_W'(used);
  assign cnt_inc  = (cnt_r == {COUNT_W{1'b1}}) ? cnt_r : cnt_r + COUNT_W'(1);

  assign match_upd = beat_i.valid && (beat_i.op == OP_COUNT) && !beat_i.hit &&
                     occupied && (val_r == beat_i.sample);
  assign append    = beat_i.valid && (beat_i.op == OP_COUNT) && !beat_i.hit &&
                     (MY_POS == CMP_W'(used));
  assign read_hit  = beat_i.valid && (beat_i.op == OP_READ) && occupied &&
                     (CMP_W'(beat_i.idx) == MY_POS);

  // Claim the beat when this cell is the one it touches
  always_comb begin
    beat_nxt = beat_i;
    hcnt_nxt = cnt_i;
    if (match_upd) begin
      beat_nxt.hit   = 1'b1;
      beat_nxt.value = val_r;
      beat_nxt.pos   = IDX_W'(INDEX);
      hcnt_nxt       = cnt_inc;
    end else if (append) begin
      beat_nxt.hit   = 1'b1;
      beat_nxt.fresh = 1'b1;
      beat_nxt.value = beat_i.sample;
      beat_nxt.pos   = IDX_W'(INDEX);
      hcnt_nxt       = COUNT_W'(1);
    end else if (read_hit) begin
      beat_nxt.hit   = 1'b1;
      beat_nxt.value = val_r;
      beat_nxt.pos   = IDX_W'(INDEX);
      hcnt_nxt       = cnt_r;
    end
  end

  // Stored entry
  always_ff @(posedge clk) begin
    if (match_upd) begin
      cnt_r <= cnt_inc;
    end else if (append) begin
      val_r <= beat_i.sample;
      cnt_r <= COUNT_W'(1);
    end
  end

  // Hand-off register to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hcnt_r <= hcnt_nxt;
  end

  assign beat_o = beat_r;
  assign cnt_o  = hcnt_r;

endmodule

### rtl/core/dvc_ctrl.sv
// Controller: takes input beats, launches them into the cell chain, applies
// fill count and full flag when a beat leaves the chain, and holds results.
// Depends on dvc_pkg and the channel interfaces.
`timescale 1ns / 1ps

module dvc_ctrl
  import dvc_pkg::*;
#(
  parameter int unsigned DEPTH   = DEPTH_DEF,
  parameter int unsigned COUNT_W = COUNT_W_DEF,
  parameter int unsigned USED_W  = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  dvc_in_if.sink             in_item,
  dvc_out_if.source          out_item,
  output logic [USED_W-1:0]  used_o,
  output beat_t              beat_o,
  input  beat_t              beat_i,
  input  logic [COUNT_W-1:0] cnt_i
);

  localparam logic [USED_W-1:0] FULL_CNT = USED_W'(DEPTH);

  state_t            state_r, state_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              ovf_r, ovf_nxt;
  beat_t             inj_r, inj_nxt;
  logic              out_valid_r;
  res_t              out_r, pend_r, res;
  logic              accept, arrive, slot_free, load_out;

  assign accept    = in_item.valid && in_item.ready;
  assign arrive    = (state_r == ST_WALK) && beat_i.valid;
  assign slot_free = !out_valid_r || out_item.ready;
  assign load_out  = (arrive || (state_r == ST_HOLD)) && slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_WALK;
      ST_WALK: if (arrive) state_nxt = slot_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_item.ready = (state_r == ST_IDLE);
  end

  // Beat launched into the chain
  always_comb begin
    inj_nxt        = '0;
    inj_nxt.valid  = accept;
    inj_nxt.op     = in_item.opcode;
    inj_nxt.sample = in_item.sample_value;
    inj_nxt.idx    = in_item.entry_index;
  end

  // Table bookkeeping for the beat leaving the chain
  always_comb begin
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    case (beat_i.op)
      OP_COUNT: begin
        if (beat_i.hit && beat_i.fresh && (used_r != FULL_CNT)) begin
          used_nxt = used_r + USED_W'(1);
        end
        if (!beat_i.hit) begin
          ovf_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        used_nxt = '0;
        ovf_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  // Result beat; entry fields read zero when nothing was touched
  always_comb begin
    res                = '0;
    res.distinct_total = TOTAL_W'(used_nxt);
    res.table_full     = ovf_nxt;
    if (beat_i.hit) begin
      res.entry_value    = beat_i.value;
      res.entry_count    = OUT_COUNT_W'(cnt_i);
      res.entry_position = beat_i.pos;
      res.was_new        = beat_i.fresh;
      res.entry_valid    = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (arrive) begin
        used_r <= used_nxt;
        ovf_r  <= ovf_nxt;
      end
      inj_r <= inj_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and skid holding register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= (state_r == ST_HOLD) ? pend_r : res;
    end
    if (arrive && !slot_free) begin
      pend_r <= res;
    end
  end

  assign used_o  = used_r;
  assign beat_o  = inj_r;

  assign out_item.valid          = out_valid_r;
  assign out_item.entry_value    = out_r.entry_value;
  assign out_item.entry_count    = out_r.entry_count;
  assign out_item.entry_position = out_r.entry_position;
  assign out_item.was_new        = out_r.was_new;
  assign out_item.entry_valid    = out_r.entry_valid;
  assign out_item.distinct_total = out_r.distinct_total;
  assign out_item.table_full     = out_r.table_full;

endmodule

### rtl/core/distinct_value_counter.sv
// Distinct value counter top level: controller plus a chain of DEPTH cells.
// Depends on dvc_pkg, dvc_ifs, dvc_cell and dvc_ctrl.
//
// Usage:
//   in_item carries one operation per beat: count a 16-bit sample, read the
//   entry at an index, or clear the table. out_item returns exactly one
//   result beat per input beat, in order.
//   Each accepted beat walks the cell chain one cell per cycle; the cell
//   that holds the sample (or the first free cell) updates its entry.
//   The result is registered once the beat leaves the last cell. A new input
//   beat is taken only after the previous one has left the chain, so at most
//   one beat is in flight.
//   A finished result waits in the output register while the next input
//   beat is accepted; if the receiver still stalls when that beat leaves
//   the chain, its result is parked in a holding register and in_ready
//   stays low until the output register frees up.
//   Reset (synchronous, active low) empties the table and clears the full
//   flag; stored values and counts keep whatever they held.
`timescale 1ns / 1ps

module distinct_value_counter
  import dvc_pkg::*;
#(
  parameter int unsigned DEPTH   = DEPTH_DEF,
  parameter int unsigned COUNT_W = COUNT_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dvc_in_if.sink    in_item,
  dvc_out_if.source out_item
);

  localparam int unsigned USED_W = $clog2(DEPTH + 1);

  logic [USED_W-1:0]  used;
  beat_t              link_beat [DEPTH+1];
  logic [COUNT_W-1:0] link_cnt  [DEPTH+1];

  dvc_ctrl #(
    .DEPTH   (DEPTH),
    .COUNT_W (COUNT_W),
    .USED_W  (USED_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .used_o   (used),
    .beat_o   (link_beat[0]),
    .beat_i   (link_beat[DEPTH]),
    .cnt_i    (link_cnt[DEPTH])
  );

  assign link_cnt[0] = '0;

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dvc_cell #(
      .INDEX   (g),
      .COUNT_W (COUNT_W),
      .USED_W  (USED_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .used   (used),
      .beat_i (link_beat[g]),
      .cnt_i  (link_cnt[g]),
      .beat_o (link_beat[g+1]),
      .cnt_o  (link_cnt[g+1])
    );
  end

endmodule

### rtl/core/dvc_checker.sv
// Port-level checks for the distinct value counter, bound to the top level.
// Depends on dvc_pkg and distinct_value_counter.
`timescale 1ns / 1ps

module dvc_checker
  import dvc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_W-1:0]     entry_value,
  input logic [OUT_COUNT_W-1:0] entry_count,
  input logic [IDX_W-1:0]       entry_position,
  input logic                   was_new,
  input logic                   entry_valid,
  input logic [TOTAL_W-1:0]     distinct_total
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(entry_value) &&
    $stable(entry_count) && $stable(entry_position) && $stable(entry_valid))
    else $error("result beat changed while stalled");

  // No entry touched: entry fields are zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !entry_valid |-> entry_value == '0 && entry_count == '0 &&
    entry_position == '0 && !was_new)
    else $error("invalid result carries entry data");

  // Appended entry starts at count one and is counted in the total
  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && was_new |-> entry_valid && entry_count == OUT_COUNT_W'(1) &&
    distinct_total != '0)
    else $error("new entry result inconsistent");

  // A valid entry means the table is not empty
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_valid |-> distinct_total != '0)
    else $error("valid entry reported with empty table");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind distinct_value_counter dvc_checker u_dvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .entry_value    (out_item.entry_value),
  .entry_count    (out_item.entry_count),
  .entry_position (out_item.entry_position),
  .was_new        (out_item.was_new),
  .entry_valid    (out_item.entry_valid),
  .distinct_total (out_item.distinct_total)
);

### bench/tally_check_pkg.sv
// Scoreboard for the distinct value counter bench: a tally table predictor
// and the queue of expected result beats. Depends on dvc_pkg.
`timescale 1ns / 1ps

package tally_check_pkg;
  import dvc_pkg::*;

  // Fourth opcode, which the block ignores
  localparam op_t OP_NOP = 2'd3;

  localparam int unsigned SLOTS = DEPTH_DEF;
  localparam logic [COUNT_W_DEF-1:0] COUNT_TOP = '1;
  localparam int unsigned SHOWN_ERRORS = 10;

  class tally_board;
    // Predicted table contents
    logic [VALUE_W-1:0]     slot_value [SLOTS];
    logic [COUNT_W_DEF-1:0] slot_count [SLOTS];
    int unsigned            used;
    logic                   full_seen;

    res_t expected_tallies [$];

    int unsigned errors;
    int unsigned checked;
    int unsigned appended;
    int unsigned drops;
    int unsigned clears;
    int unsigned reads_hit;

    function new();
      used      = 0;
      full_seen = 1'b0;
      errors    = 0;
      checked   = 0;
      appended  = 0;
      drops     = 0;
      clears    = 0;
      reads_hit = 0;
    endfunction

    // Result fields describing one live table slot
    function res_t tally_of(int unsigned slot, logic fresh);
      res_t r;
      r                = '0;
      r.entry_value    = slot_value[slot];
      r.entry_count    = slot_count[slot][OUT_COUNT_W-1:0];
      r.entry_position = slot[IDX_W-1:0];
      r.was_new        = fresh;
      r.entry_valid    = 1'b1;
      return r;
    endfunction

    // Update the predicted table for one accepted input beat
    function void note_beat(op_t op, logic [VALUE_W-1:0] sample, logic [IDX_W-1:0] idx);
      res_t r;
      int   hit;
      r   = '0;
      hit = -1;
      case (op)
        OP_COUNT: begin
          for (int i = 0; i < used; i++)
            if (hit < 0 && slot_value[i] == sample) hit = i;
          if (hit >= 0) begin
            if (slot_count[hit] != COUNT_TOP) slot_count[hit] = slot_count[hit] + 1'b1;
            r = tally_of(hit, 1'b0);
          end else if (used < SLOTS) begin
            slot_value[used] = sample;
            slot_count[used] = 1;
            used++;
            appended++;
            r = tally_of(used - 1, 1'b1);
          end else begin
            // table full: value dropped, flag sticks until a clear
            full_seen = 1'b1;
            drops++;
          end
        end
        OP_READ: begin
          if (idx < used) begin
            r = tally_of(idx, 1'b0);
            reads_hit++;
          end
        end
        OP_CLEAR: begin
          used      = 0;
          full_seen = 1'b0;
          clears++;
        end
        default: ;
      endcase
      r.distinct_total = used[TOTAL_W-1:0];
      r.table_full     = full_seen;
      expected_tallies.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf("value=%h count=%0d pos=%0d new=%b valid=%b total=%0d full=%b",
                       r.entry_value, r.entry_count, r.entry_position, r.was_new,
                       r.entry_valid, r.distinct_total, r.table_full);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_tally(res_t got);
      res_t  want;
      string bad;
      bad = "";
      if (expected_tallies.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("unexpected result beat: %s", show(got));
        return;
      end
      want = expected_tallies.pop_front();
      checked++;
      if (got.entry_value    !== want.entry_value)    bad = {bad, " entry_value"};
      if (got.entry_count    !== want.entry_count)    bad = {bad, " entry_count"};
      if (got.entry_position !== want.entry_position) bad = {bad, " entry_position"};
      if (got.was_new        !== want.was_new)        bad = {bad, " was_new"};
      if (got.entry_valid    !== want.entry_valid)    bad = {bad, " entry_valid"};
      if (got.distinct_total !== want.distinct_total) bad = {bad, " distinct_total"};
      if (got.table_full     !== want.table_full)     bad = {bad, " table_full"};
      if (bad != "") begin
        errors++;
        if (errors <= SHOWN_ERRORS) begin
          $display("result %0d differs in%s", checked, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    // Anything still queued at the end never came out
    function void close_out();
      if (expected_tallies.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", expected_tallies.size());
      end
    endfunction
  endclass

endpackage

### bench/testbench.sv
// Top-level bench for distinct_value_counter: directed and random beats,
// random idling on both channels, one long receiver hold-off.
// Depends on dvc_pkg, dvc_ifs, tally_check_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import dvc_pkg::*;
  import tally_check_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1150;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = DEPTH_DEF + 16;

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int unsigned sent = 0;

  logic [VALUE_W-1:0] sample_pool [$];
  tally_board board = new();

  dvc_in_if  in_ch ();
  dvc_out_if out_ch ();

  distinct_value_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  always #4 clk = ~clk;

  // Offer one beat, maybe after a short idle burst, and wait for acceptance
  task automatic offer(op_t op, logic [VALUE_W-1:0] sample, logic [IDX_W-1:0] idx);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_value <= sample;
    in_ch.entry_index  <= idx;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_beat(op, sample, idx);
    sent++;
    calm = (sent + CALM_TAIL >= RANDOM_BEATS);
  endtask

  task automatic directed_beats();
    offer(OP_READ,  16'h0000, 6'd0);   // read on an empty table
    offer(OP_COUNT, 16'h0000, 6'd63);  // lowest value, appended
    offer(OP_COUNT, 16'hFFFF, 6'd0);   // highest value, appended
    offer(OP_COUNT, 16'h0000, 6'd0);   // hits
    offer(OP_COUNT, 16'hFFFF, 6'd63);
    offer(OP_COUNT, 16'hA5A5, 6'd0);
    offer(OP_COUNT, 16'h5A5A, 6'd0);
    offer(OP_READ,  16'hFFFF, 6'd0);
    offer(OP_READ,  16'h0000, 6'd3);   // last stored entry
    offer(OP_READ,  16'h0000, 6'd4);   // just past the end
    offer(OP_READ,  16'h0000, 6'd63);
    offer(OP_NOP,   16'hFFFF, 6'd63);
    offer(OP_NOP,   16'h0000, 6'd0);
    offer(OP_CLEAR, 16'hFFFF, 6'd63);
    offer(OP_READ,  16'h0000, 6'd0);   // stale slots are gone after clear
    offer(OP_COUNT, 16'hFFFF, 6'd0);   // stale value must not match
    offer(OP_COUNT, 16'h5A5A, 6'd0);
    offer(OP_COUNT, 16'h5A5A, 6'd0);
    offer(OP_READ,  16'h0000, 6'd1);
    offer(OP_CLEAR, 16'h0000, 6'd0);
  endtask

  // One random beat drawn mostly from the current sample pool
  task automatic random_op();
    int unsigned roll;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    idx  = IDX_W'($urandom_range(0, 63));
    if (roll < 62) begin
      offer(OP_COUNT, sample_pool[$urandom_range(0, sample_pool.size() - 1)], idx);
    end else if (roll < 70) begin
      offer(OP_COUNT, VALUE_W'($urandom), idx);
    end else if (roll < 92) begin
      // half the reads aim inside the stored entries
      if (roll >= 81 && board.used != 0) idx = IDX_W'($urandom_range(0, board.used - 1));
      offer(OP_READ, VALUE_W'($urandom), idx);
    end else if (roll < 96) begin
      offer(OP_CLEAR, VALUE_W'($urandom), idx);
    end else begin
      offer(OP_NOP, VALUE_W'($urandom), idx);
    end
  endtask

  // A fill segment clears, appends more distinct values than fit, then mixes
  task automatic random_segment(bit fill);
    logic [VALUE_W-1:0] base;
    int unsigned width;
    int unsigned ops;
    int unsigned k;
    base = VALUE_W'($urandom);
    sample_pool.delete();
    width = fill ? DEPTH_DEF + $urandom_range(1, 12) : $urandom_range(1, 40);
    for (k = 0; k < width; k++)
      sample_pool.push_back(fill ? base + k[VALUE_W-1:0] : VALUE_W'($urandom));
    if (fill) begin
      offer(OP_CLEAR, VALUE_W'($urandom), IDX_W'($urandom));
      foreach (sample_pool[j]) offer(OP_COUNT, sample_pool[j], IDX_W'($urandom));
    end
    ops = $urandom_range(40, 110);
    repeat (ops) if (sent < RANDOM_BEATS) random_op();
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    bit first;
    first = 1'b1;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_COUNT;
    in_ch.sample_value <= '0;
    in_ch.entry_index  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_beats();
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      random_segment(first || $urandom_range(0, 2) == 0);
      first = 1'b0;
    end
    in_ch.valid <= 1'b0;
    while (board.expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();
    $display("covered %0d results: %0d appended, %0d dropped on a full table, %0d clears",
             board.checked, board.appended, board.drops, board.clears);
    $display("%0d in-range reads; one %0d-cycle receiver hold-off with the input backed up",
             board.reads_hit, HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, steady at the end
  initial begin : receiver
    int unsigned n;
    logic held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && board.checked >= 120) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        out_ch.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : monitor
    res_t got;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.entry_value    = out_ch.entry_value;
      got.entry_count    = out_ch.entry_count;
      got.entry_position = out_ch.entry_position;
      got.was_new        = out_ch.was_new;
      got.entry_valid    = out_ch.entry_valid;
      got.distinct_total = out_ch.distinct_total;
      got.table_full     = out_ch.table_full;
      board.check_tally(got);
    end
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", board.expected_tallies.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
